FILE: sv/wsfd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result codes,
// opcodes, the result record and opcode helper functions.
// Depends on nothing; used by wsfd_parser and websocket_frame_deframer_top.
package wsfd_pkg;

    localparam int LEN_W = 63;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASKKEY = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_HALT    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NO_FIN     = 2'd0,
        ERR_BAD_OPCODE = 2'd1,
        ERR_LEN_TOPBIT = 2'd2
    } err_t;

    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [3:0] LEN16_BYTES    = 4'd2;
    localparam logic [3:0] LEN64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
        logic             last;
        err_t             err;
    } wsfd_result_t;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_TEXT) || (op == OP_BINARY);
    endfunction

    function automatic logic is_control_op(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

FILE: sv/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: byte input, result register.
// Depends on wsfd_pkg and wsfd_parser.
//
//   channel   handshake              fields
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  kind, frame_opcode_out, frame_length,
//                                    data_byte, last, error_code
//
// One byte per cycle while in_ready; a result comes in the cycle after its byte.
// The per-byte path is one 63-bit decrement and compare on the payload count.
// Reset clears the parse state and empties the result register.
// A new byte is taken while the result register is empty or being drained.
module websocket_frame_deframer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       kind,
    output logic [3:0]                       frame_opcode_out,
    output logic [wsfd_pkg::LEN_W-1:0]       frame_length,
    output logic [7:0]                       data_byte,
    output logic                             last,
    output logic [1:0]                       error_code
);

    wsfd_pkg::wsfd_result_t res;
    wsfd_pkg::wsfd_result_t out_reg;
    logic                   out_valid_reg;
    logic                   step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    wsfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= res.valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
            out_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_reg.kind;
    assign frame_opcode_out = out_reg.opcode;
    assign frame_length     = out_reg.length;
    assign data_byte        = out_reg.data;
    assign last             = out_reg.last;
    assign error_code       = out_reg.err;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("input stalled with room in the result register");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid |=> out_valid_reg)
        else $error("result was not registered");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while waiting");
`endif

endmodule

FILE: sv/wsfd_parser.sv
// Frame parse state and the per-byte decode logic of the deframer.
// Depends on wsfd_pkg; produces at most one result record per accepted byte.
module wsfd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output wsfd_pkg::wsfd_result_t res
);

    wsfd_pkg::phase_t                phase_reg, phase_next;
    logic [3:0]                      opcode_reg, opcode_next;
    logic                            masked_reg, masked_next;
    logic [63:0]                     accum_reg, accum_next;
    logic [3:0]                      hdr_left_reg, hdr_left_next;
    logic [31:0]                     key_reg, key_next;
    logic [1:0]                      idx_reg, idx_next;
    logic [wsfd_pkg::LEN_W-1:0]      left_reg, left_next;

    logic [6:0]                      len7;
    logic                            hdr_done;
    logic                            ext_top;
    logic [wsfd_pkg::LEN_W-1:0]      ext_len;
    logic [7:0]                      key_byte;

    assign len7     = rx_byte[6:0];
    assign hdr_done = (hdr_left_reg == 4'd1);
    assign ext_top  = accum_reg[55];
    assign ext_len  = {accum_reg[54:0], rx_byte};

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    if (!rx_byte[7])
                        phase_next = wsfd_pkg::PH_HALT;
                    else if (!wsfd_pkg::is_data_op(rx_byte[3:0]) &&
                             !wsfd_pkg::is_control_op(rx_byte[3:0]))
                        phase_next = wsfd_pkg::PH_HALT;
                    else
                        phase_next = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1:
                begin
                    if (len7 == wsfd_pkg::LEN16_CODE || len7 == wsfd_pkg::LEN64_CODE)
                        phase_next = wsfd_pkg::PH_EXTLEN;
                    else if (rx_byte[7])
                        phase_next = wsfd_pkg::PH_MASKKEY;
                    else if (len7 != 7'd0)
                        phase_next = wsfd_pkg::PH_PAYLOAD;
                    else
                        phase_next = wsfd_pkg::PH_HDR0;
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    if (hdr_done)
                    begin
                        if (ext_top)
                            phase_next = wsfd_pkg::PH_HALT;
                        else if (masked_reg)
                            phase_next = wsfd_pkg::PH_MASKKEY;
                        else if (ext_len != '0)
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                        else
                            phase_next = wsfd_pkg::PH_HDR0;
                    end
                end
                wsfd_pkg::PH_MASKKEY:
                begin
                    if (hdr_done)
                        phase_next = (left_reg != '0) ? wsfd_pkg::PH_PAYLOAD
                                                      : wsfd_pkg::PH_HDR0;
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    if (left_reg == wsfd_pkg::LEN_W'(1))
                        phase_next = wsfd_pkg::PH_HDR0;
                end
                wsfd_pkg::PH_HALT:
                    phase_next = wsfd_pkg::PH_HALT;
                default:
                    phase_next = wsfd_pkg::PH_HDR0;
            endcase
        end
    end

    always_comb
    begin
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        accum_next    = accum_reg;
        hdr_left_next = hdr_left_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        res           = '0;
        res.kind      = wsfd_pkg::KIND_HEADER;
        res.err       = wsfd_pkg::ERR_NO_FIN;
        res.opcode    = opcode_reg;
        if (step)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR0:
                begin
                    if (!rx_byte[7])
                    begin
                        res.valid  = 1'b1;
                        res.kind   = wsfd_pkg::KIND_ERROR;
                        res.opcode = rx_byte[3:0];
                        res.err    = wsfd_pkg::ERR_NO_FIN;
                    end
                    else if (!wsfd_pkg::is_data_op(rx_byte[3:0]) &&
                             !wsfd_pkg::is_control_op(rx_byte[3:0]))
                    begin
                        res.valid  = 1'b1;
                        res.kind   = wsfd_pkg::KIND_ERROR;
                        res.opcode = rx_byte[3:0];
                        res.err    = wsfd_pkg::ERR_BAD_OPCODE;
                    end
                    else
                    begin
                        opcode_next = rx_byte[3:0];
                    end
                end
                wsfd_pkg::PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    accum_next  = '0;
                    if (len7 == wsfd_pkg::LEN16_CODE)
                        hdr_left_next = wsfd_pkg::LEN16_BYTES;
                    else if (len7 == wsfd_pkg::LEN64_CODE)
                        hdr_left_next = wsfd_pkg::LEN64_BYTES;
                    else
                    begin
                        left_next = wsfd_pkg::LEN_W'(len7);
                        if (rx_byte[7])
                            hdr_left_next = wsfd_pkg::MASK_KEY_BYTES;
                        else
                        begin
                            idx_next      = 2'd0;
                            hdr_left_next = 4'd0;
                            res.valid     = 1'b1;
                            res.length    = wsfd_pkg::LEN_W'(len7);
                            res.last      = wsfd_pkg::is_data_op(opcode_reg) &&
                                            (len7 == 7'd0);
                        end
                    end
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    accum_next    = {accum_reg[55:0], rx_byte};
                    hdr_left_next = hdr_left_reg - 4'd1;
                    if (hdr_done)
                    begin
                        if (ext_top)
                        begin
                            res.valid = 1'b1;
                            res.kind  = wsfd_pkg::KIND_ERROR;
                            res.err   = wsfd_pkg::ERR_LEN_TOPBIT;
                        end
                        else
                        begin
                            left_next = ext_len;
                            if (masked_reg)
                                hdr_left_next = wsfd_pkg::MASK_KEY_BYTES;
                            else
                            begin
                                idx_next   = 2'd0;
                                res.valid  = 1'b1;
                                res.length = ext_len;
                                res.last   = wsfd_pkg::is_data_op(opcode_reg) &&
                                             (ext_len == '0);
                            end
                        end
                    end
                end
                wsfd_pkg::PH_MASKKEY:
                begin
                    key_next      = {key_reg[23:0], rx_byte};
                    hdr_left_next = hdr_left_reg - 4'd1;
                    if (hdr_done)
                    begin
                        idx_next   = 2'd0;
                        res.valid  = 1'b1;
                        res.length = left_reg;
                        res.last   = wsfd_pkg::is_data_op(opcode_reg) && (left_reg == '0);
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    idx_next  = idx_reg + 2'd1;
                    left_next = left_reg - wsfd_pkg::LEN_W'(1);
                    if (wsfd_pkg::is_data_op(opcode_reg))
                    begin
                        res.valid = 1'b1;
                        res.kind  = wsfd_pkg::KIND_PAYLOAD;
                        res.data  = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                        res.last  = (left_reg == wsfd_pkg::LEN_W'(1));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wsfd_pkg::PH_HDR0;
            opcode_reg   <= 4'd0;
            masked_reg   <= 1'b0;
            accum_reg    <= '0;
            hdr_left_reg <= 4'd0;
            key_reg      <= '0;
            idx_reg      <= 2'd0;
            left_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            accum_reg    <= accum_next;
            hdr_left_reg <= hdr_left_next;
            key_reg      <= key_next;
            idx_reg      <= idx_next;
            left_reg     <= left_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_HALT |=> phase_reg == wsfd_pkg::PH_HALT)
        else $error("parser left the halted phase");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_PAYLOAD |-> left_reg != '0)
        else $error("payload phase with no bytes left");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == wsfd_pkg::KIND_ERROR |=> phase_reg == wsfd_pkg::PH_HALT)
        else $error("error result without halting");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsfd_pkg::PH_EXTLEN || phase_reg == wsfd_pkg::PH_MASKKEY)
        |-> hdr_left_reg != 4'd0)
        else $error("header byte count ran out");
`endif

endmodule
